@@ hdl/pic_pkg.sv @@
// Package for the PI controller with integral separation.
// Holds widths, register codes, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package pic_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ERR_W     = SAMPLE_W + 1;
  localparam int unsigned INTEG_W   = 32;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  // product widths: signed value times gain with a zero sign bit added
  localparam int unsigned PPROD_W = ERR_W + GAIN_W + 1;
  localparam int unsigned IPROD_W = INTEG_W + GAIN_W + 1;
  localparam int unsigned SUM_W   = IPROD_W + 1;
  localparam int unsigned IPART_W = SUM_W - FRAC_BITS;

  localparam logic [DUTY_W-1:0]   DUTY_MAX         = 7'd100;
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = 24'd6554;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = 24'd983;
  localparam logic [THRESH_W-1:0] INTEG_THRESH_RST = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 2'd0,
    CFG_INTEG_GAIN   = 2'd1,
    CFG_INTEG_THRESH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [THRESH_W-1:0] integ_threshold;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/pic_if.sv @@
// Valid/ready channel interfaces for the PI controller: sample, result and
// configuration write. Depends on pic_pkg.
`default_nettype none

interface pic_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [pic_pkg::SAMPLE_W-1:0] target;
  logic signed [pic_pkg::SAMPLE_W-1:0] measured;

  modport source (output valid, target, measured, input ready);
  modport sink   (input valid, target, measured, output ready);
endinterface

interface pic_result_if;
  logic                        valid;
  logic                        ready;
  logic [pic_pkg::DUTY_W-1:0]  duty;
  logic                        integrating;
  logic                        clamped;

  modport source (output valid, duty, integrating, clamped, input ready);
  modport sink   (input valid, duty, integrating, clamped, output ready);
endinterface

interface pic_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pic_pkg::CFG_IDX_W-1:0]  index;
  logic [pic_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/pic_cfg_regs.sv @@
// Configuration register file: gains and integration threshold.
// Depends on pic_pkg and pic_cfg_if.
`default_nettype none

module pic_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  pic_cfg_if.sink        cfg_i,
  output pic_pkg::cfg_t  cfg_o
);
  import pic_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PROP_GAIN:    cfg_d.prop_gain       = cfg_i.data;
        CFG_INTEG_GAIN:   cfg_d.integ_gain      = cfg_i.data;
        CFG_INTEG_THRESH: cfg_d.integ_threshold = cfg_i.data[THRESH_W-1:0];
        default:          cfg_d = cfg_q; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= PROP_GAIN_RST;
      cfg_q.integ_gain      <= INTEG_GAIN_RST;
      cfg_q.integ_threshold <= INTEG_THRESH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/pic_integrator.sv @@
// Error stage: error, separation test and saturating integral.
// Holds the running integral. Depends on pic_pkg.
`default_nettype none

module pic_integrator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic signed [pic_pkg::SAMPLE_W-1:0] target_i,
  input  wire logic signed [pic_pkg::SAMPLE_W-1:0] measured_i,
  input  wire logic [pic_pkg::THRESH_W-1:0]        threshold_i,
  output logic signed [pic_pkg::ERR_W-1:0]         err_o,
  output logic signed [pic_pkg::INTEG_W-1:0]       integral_o,
  output logic                                     integrating_o
);
  import pic_pkg::*;

  logic signed [ERR_W-1:0]   err;
  logic        [ERR_W-1:0]   abs_err;
  logic                      integ;
  logic signed [INTEG_W:0]   raw_sum;
  logic signed [INTEG_W-1:0] sat_sum;
  logic signed [INTEG_W-1:0] integral_q, integral_d;
  logic signed [ERR_W-1:0]   err_q;
  logic                      integ_q;

  assign err     = ERR_W'(measured_i) - ERR_W'(target_i);
  assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign integ   = abs_err <= ERR_W'(threshold_i);

  assign raw_sum = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err);

  // overflow when the two top bits disagree: pin to the rail of that sign
  always_comb begin
    if (raw_sum[INTEG_W] != raw_sum[INTEG_W-1]) begin
      sat_sum = {raw_sum[INTEG_W], {(INTEG_W-1){~raw_sum[INTEG_W]}}};
    end else begin
      sat_sum = raw_sum[INTEG_W-1:0];
    end
    integral_d = integ ? sat_sum : integral_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
    end else if (load_i) begin
      integral_q <= integral_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q   <= err;
      integ_q <= integ;
    end
  end

  assign err_o         = err_q;
  assign integral_o    = integral_q;
  assign integrating_o = integ_q;

endmodule

`default_nettype wire

@@ hdl/pic_gain_mul.sv @@
// Gain stage: proportional and integral products, registered.
// Depends on pic_pkg.
`default_nettype none

module pic_gain_mul (
  input  wire logic                               clk_i,
  input  wire logic                               load_i,
  input  wire logic signed [pic_pkg::ERR_W-1:0]   err_i,
  input  wire logic signed [pic_pkg::INTEG_W-1:0] integral_i,
  input  wire logic [pic_pkg::GAIN_W-1:0]         prop_gain_i,
  input  wire logic [pic_pkg::GAIN_W-1:0]         integ_gain_i,
  output logic signed [pic_pkg::PPROD_W-1:0]      p_term_o,
  output logic signed [pic_pkg::IPROD_W-1:0]      i_term_o
);
  import pic_pkg::*;

  logic signed [PPROD_W-1:0] p_term_d, p_term_q;
  logic signed [IPROD_W-1:0] i_term_d, i_term_q;

  // gains are unsigned: a zero sign bit makes them safe signed operands
  assign p_term_d = PPROD_W'(err_i) * PPROD_W'($signed({1'b0, prop_gain_i}));
  assign i_term_d = IPROD_W'(integral_i) * IPROD_W'($signed({1'b0, integ_gain_i}));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_term_q <= p_term_d;
      i_term_q <= i_term_d;
    end
  end

  assign p_term_o = p_term_q;
  assign i_term_o = i_term_q;

endmodule

`default_nettype wire

@@ hdl/pic_duty_clamp.sv @@
// Output logic: sum of terms, integer part and clamp to 0..100.
// Depends on pic_pkg.
`default_nettype none

module pic_duty_clamp (
  input  wire logic signed [pic_pkg::PPROD_W-1:0] p_term_i,
  input  wire logic signed [pic_pkg::IPROD_W-1:0] i_term_i,
  output logic [pic_pkg::DUTY_W-1:0]              duty_o,
  output logic                                    clamped_o
);
  import pic_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic [IPART_W-1:0]      int_part;

  assign sum      = SUM_W'(p_term_i) + SUM_W'(i_term_i);
  assign int_part = sum[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (sum[SUM_W-1]) begin
      duty_o    = '0;
      clamped_o = 1'b1;
    end else if (int_part > IPART_W'(DUTY_MAX)) begin
      duty_o    = DUTY_MAX;
      clamped_o = 1'b1;
    end else begin
      duty_o    = int_part[DUTY_W-1:0];
      clamped_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pi_controller_integral_separation.sv @@
// PI controller with integral separation, top level.
// Depends on pic_pkg, pic_if, pic_cfg_regs, pic_integrator, pic_gain_mul
// and pic_duty_clamp.
//
// Use:
//   sample_i carries one word per sample (target, measured). Each accepted
//   word yields exactly one word on result_o (duty 0..100, integrating,
//   clamped), in order. cfg_i writes prop_gain (index 0), integ_gain (1) or
//   integ_threshold (2); it is always ready and should only be written while
//   no sample is in flight. Other indexes are ignored.
// Timing:
//   Four registered stages: input register, error/integral, gain products,
//   result register. One sample per cycle is sustained while result_o.ready
//   stays high; the integral add-and-saturate is the only feedback loop and
//   it closes within the error stage.
// Stall:
//   Each stage has its own valid bit and takes a word when it is empty or
//   its successor moves on, so a held result does not block the stages
//   behind it until all four are full; then sample_i.ready drops.
// Reset:
//   rst_ni clears all valid bits and the integral, and loads the gains and
//   threshold with their default values (about 0.1, 0.015 and 300).
`default_nettype none

module pi_controller_integral_separation (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pic_sample_if.sink   sample_i,
  pic_cfg_if.sink      cfg_i,
  pic_result_if.source result_o
);
  import pic_pkg::*;

  cfg_t cfg;

  // stage valid bits
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;
  logic ld0, ld1, ld2, ld3;

  // input register
  logic signed [SAMPLE_W-1:0] target_q, measured_q;

  // stage outputs
  logic signed [ERR_W-1:0]   err1;
  logic signed [INTEG_W-1:0] integral1;
  logic                      integ1;
  logic                      integ2_q;
  logic signed [PPROD_W-1:0] p_term2;
  logic signed [IPROD_W-1:0] i_term2;
  logic [DUTY_W-1:0]         duty3;
  logic                      clamped3;

  // result register
  logic [DUTY_W-1:0] duty_q;
  logic              integ_q;
  logic              clamped_q;

  // a stage can take a word when empty or when its word leaves this cycle
  assign rdy3 = !v3_q || result_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign ld0 = sample_i.valid && rdy0;
  assign ld1 = v0_q && rdy1;
  assign ld2 = v1_q && rdy2;
  assign ld3 = v2_q && rdy3;

  assign sample_i.ready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= sample_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld0) begin
      target_q   <= sample_i.target;
      measured_q <= sample_i.measured;
    end
    if (ld2) begin
      integ2_q <= integ1;
    end
    if (ld3) begin
      duty_q    <= duty3;
      integ_q   <= integ2_q;
      clamped_q <= clamped3;
    end
  end

  pic_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // integral advances only when a word enters the error stage
  pic_integrator u_integrator (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (ld1),
    .target_i      (target_q),
    .measured_i    (measured_q),
    .threshold_i   (cfg.integ_threshold),
    .err_o         (err1),
    .integral_o    (integral1),
    .integrating_o (integ1)
  );

  pic_gain_mul u_gain_mul (
    .clk_i        (clk_i),
    .load_i       (ld2),
    .err_i        (err1),
    .integral_i   (integral1),
    .prop_gain_i  (cfg.prop_gain),
    .integ_gain_i (cfg.integ_gain),
    .p_term_o     (p_term2),
    .i_term_o     (i_term2)
  );

  pic_duty_clamp u_duty_clamp (
    .p_term_i  (p_term2),
    .i_term_i  (i_term2),
    .duty_o    (duty3),
    .clamped_o (clamped3)
  );

  assign result_o.valid       = v3_q;
  assign result_o.duty        = duty_q;
  assign result_o.integrating = integ_q;
  assign result_o.clamped     = clamped_q;

endmodule

`default_nettype wire
